// ----- src/cafr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cafr_pkg: shared types for the command APDU framer
// Status codes, frame state, and the burst of bytes one item produces.
// ----------------------------------------------------------------------------
package cafr_pkg;

	localparam int BURST_MAX = 7;
	localparam int CNT_W     = $clog2(BURST_MAX + 1);

	localparam logic       OP_HEADER = 1'b0;
	localparam logic       OP_DATA   = 1'b1;
	localparam logic [1:0] PROTO_T1  = 2'd1;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_EXT_NEEDS_T1 = 3'd1,
		ST_NC_TOO_LARGE = 3'd2,
		ST_NE_TOO_LARGE = 3'd3,
		ST_UNEXPECTED   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		LE_NONE = 2'd0,
		LE_ONE  = 2'd1,
		LE_TWO  = 2'd2
	} le_mode_t;

	typedef struct packed {
		logic [15:0] data_left;
		logic [16:0] saved_resp_len;
		le_mode_t    le_mode;
		logic        in_frame;
	} frame_state_t;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} beat_t;

	typedef struct packed {
		beat_t [BURST_MAX-1:0] beats;
		status_t               status;
		logic [CNT_W-1:0]      cnt;
	} burst_t;

endpackage

// ----- src/cafr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cafr_if: stream channels of the command APDU framer
// Command item channel and frame byte channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cafr_cmd_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [7:0]  cla;
	logic [7:0]  ins;
	logic [7:0]  p1;
	logic [7:0]  p2;
	logic [15:0] data_len;
	logic [16:0] resp_len;
	logic        extended;
	logic [7:0]  data_byte;

	modport source (
		output valid, op, cla, ins, p1, p2, data_len, resp_len, extended, data_byte,
		input  ready
	);
	modport sink (
		input  valid, op, cla, ins, p1, p2, data_len, resp_len, extended, data_byte,
		output ready
	);
endinterface

interface cafr_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;
	logic [2:0] status;

	modport source (output valid, out_byte, last, status, input ready);
	modport sink   (input valid, out_byte, last, status, output ready);
endinterface

// ----- src/cafr_encode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cafr_encode: per-item APDU encoder
// Checks a header or data item against the frame state and builds the burst
// of frame bytes it causes, together with the next frame state.
// ----------------------------------------------------------------------------
module cafr_encode import cafr_pkg::*; (
	input  logic         op,
	input  logic [7:0]   cla,
	input  logic [7:0]   ins,
	input  logic [7:0]   p1,
	input  logic [7:0]   p2,
	input  logic [15:0]  data_len,
	input  logic [16:0]  resp_len,
	input  logic         extended,
	input  logic [7:0]   data_byte,
	input  logic [1:0]   link_protocol,
	input  frame_state_t state,
	output burst_t       burst,
	output frame_state_t state_nxt
);

	logic open_frame;
	logic nc_zero, ne_zero;
	logic nc_gt255, ne_gt256, ne_gt64k;
	logic short_lc;
	logic end_data;

	assign open_frame = state.in_frame && (state.data_left != 16'd0);
	assign nc_zero    = (data_len == 16'd0);
	assign ne_zero    = (resp_len == 17'd0);
	assign nc_gt255   = |data_len[15:8];
	assign ne_gt256   = resp_len[16] | (|resp_len[15:9]) | (resp_len[8] & (|resp_len[7:0]));
	assign ne_gt64k   = resp_len[16] & (|resp_len[15:0]);
	assign short_lc   = ne_zero ? !nc_gt255 : (!nc_gt255 && !ne_gt256);
	assign end_data   = (state.data_left == 16'd1);

	always_comb begin
		burst     = '0;
		state_nxt = state;
		if (op == OP_DATA) begin
			if (!open_frame) begin
				burst.status         = ST_UNEXPECTED;
				burst.beats[0].last  = 1'b1;
				burst.cnt            = CNT_W'(1);
			end else begin
				burst.status          = ST_OK;
				burst.beats[0].value  = data_byte;
				burst.beats[0].last   = end_data && (state.le_mode == LE_NONE);
				burst.cnt             = CNT_W'(1);
				state_nxt.data_left   = state.data_left - 16'd1;
				if (end_data) begin
					case (state.le_mode)
						LE_ONE: begin
							burst.beats[1] = '{value: state.saved_resp_len[7:0], last: 1'b1};
							burst.cnt      = CNT_W'(2);
						end
						LE_TWO: begin
							burst.beats[1] = '{value: state.saved_resp_len[15:8], last: 1'b0};
							burst.beats[2] = '{value: state.saved_resp_len[7:0], last: 1'b1};
							burst.cnt      = CNT_W'(3);
						end
						default: begin
						end
					endcase
					state_nxt = '0;
				end
			end
		end else if (state.in_frame) begin
			// header inside a frame: abandon the open frame
			state_nxt           = '0;
			burst.status        = ST_UNEXPECTED;
			burst.beats[0].last = 1'b1;
			burst.cnt           = CNT_W'(1);
		end else if (extended && (link_protocol != PROTO_T1)) begin
			burst.status        = ST_EXT_NEEDS_T1;
			burst.beats[0].last = 1'b1;
			burst.cnt           = CNT_W'(1);
		end else if (!extended && nc_gt255) begin
			burst.status        = ST_NC_TOO_LARGE;
			burst.beats[0].last = 1'b1;
			burst.cnt           = CNT_W'(1);
		end else if (extended ? ne_gt64k : ne_gt256) begin
			burst.status        = ST_NE_TOO_LARGE;
			burst.beats[0].last = 1'b1;
			burst.cnt           = CNT_W'(1);
		end else begin
			burst.status   = ST_OK;
			burst.beats[0] = '{value: cla, last: 1'b0};
			burst.beats[1] = '{value: ins, last: 1'b0};
			burst.beats[2] = '{value: p1,  last: 1'b0};
			burst.beats[3] = '{value: p2,  last: 1'b0};
			if (nc_zero) begin
				if (ne_zero) begin
					burst.beats[3].last = 1'b1;
					burst.cnt           = CNT_W'(4);
				end else if (!ne_gt256) begin
					burst.beats[4] = '{value: resp_len[7:0], last: 1'b1};
					burst.cnt      = CNT_W'(5);
				end else begin
					burst.beats[4] = '{value: 8'h00, last: 1'b0};
					burst.beats[5] = '{value: resp_len[15:8], last: 1'b0};
					burst.beats[6] = '{value: resp_len[7:0], last: 1'b1};
					burst.cnt      = CNT_W'(7);
				end
			end else begin
				if (short_lc) begin
					burst.beats[4]    = '{value: data_len[7:0], last: 1'b0};
					burst.cnt         = CNT_W'(5);
					state_nxt.le_mode = ne_zero ? LE_NONE : LE_ONE;
				end else begin
					burst.beats[4]    = '{value: 8'h00, last: 1'b0};
					burst.beats[5]    = '{value: data_len[15:8], last: 1'b0};
					burst.beats[6]    = '{value: data_len[7:0], last: 1'b0};
					burst.cnt         = CNT_W'(7);
					state_nxt.le_mode = ne_zero ? LE_NONE : LE_TWO;
				end
				state_nxt.data_left      = data_len;
				state_nxt.saved_resp_len = resp_len;
				state_nxt.in_frame       = 1'b1;
			end
		end
	end

endmodule

// ----- src/command_apdu_framer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_apdu_framer_core: ISO 7816-4 command APDU byte framer
//
// Items arrive on cmd: a header item (op 0) opens a frame, data items (op 1)
// carry one command byte each. Frame bytes leave on frame, one per beat,
// with last on the final byte of a frame and on every error beat; an error
// beat carries a nonzero status and byte 00.
// cfg_wr_en/cfg_wr_data set the link protocol; write it only while idle.
//
// Each accepted item is encoded combinationally and loaded into a burst
// register that holds up to seven bytes; its first byte is valid the cycle
// after the accept. A header yields 1 to 7 bytes, a data item 1 to 3, so a
// data stream runs at one byte per cycle while frame.ready is high, and
// header bursts hold off intake for their length. The next item is taken
// in the cycle the burst's final byte leaves, so back-to-back items see no
// bubble. When frame.ready is low the current byte holds and intake stops
// while the burst register holds any byte. Reset empties the burst register,
// closes any open frame and sets the link protocol to T0.
// ----------------------------------------------------------------------------
module command_apdu_framer_core import cafr_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	cafr_cmd_if.sink       cmd,
	cafr_frame_if.source   frame,
	input  logic           cfg_wr_en,
	input  logic [1:0]     cfg_wr_data
);

	logic [1:0]            link_protocol_q;
	frame_state_t          state_q;
	frame_state_t          state_nxt;
	burst_t                burst;
	beat_t [BURST_MAX-1:0] beats_q;
	status_t               status_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  in_fire;
	logic                  out_fire;

	cafr_encode u_encode (
		.op            (cmd.op),
		.cla           (cmd.cla),
		.ins           (cmd.ins),
		.p1            (cmd.p1),
		.p2            (cmd.p2),
		.data_len      (cmd.data_len),
		.resp_len      (cmd.resp_len),
		.extended      (cmd.extended),
		.data_byte     (cmd.data_byte),
		.link_protocol (link_protocol_q),
		.state         (state_q),
		.burst         (burst),
		.state_nxt     (state_nxt)
	);

	assign out_fire  = frame.valid && frame.ready;
	assign cmd.ready = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && frame.ready);
	assign in_fire   = cmd.valid && cmd.ready;

	assign frame.valid    = (cnt_q != '0);
	assign frame.out_byte = beats_q[0].value;
	assign frame.last     = beats_q[0].last;
	assign frame.status   = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_protocol_q <= 2'd0;
			state_q         <= '0;
			cnt_q           <= '0;
		end else begin
			if (cfg_wr_en) begin
				link_protocol_q <= cfg_wr_data;
			end
			if (in_fire) begin
				state_q <= state_nxt;
				cnt_q   <= burst.cnt;
			end else if (out_fire) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// burst payload: load on accept, advance one byte per output beat
	always_ff @(posedge clk) begin
		if (in_fire) begin
			beats_q  <= burst.beats;
			status_q <= burst.status;
		end else if (out_fire) begin
			beats_q <= beats_q >> $bits(beat_t);
		end
	end

endmodule

// ----- src/cafr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cafr_checker: port-level checks for the command APDU framer
// Watches the item and frame channels and flags broken framing behavior.
// ----------------------------------------------------------------------------
module cafr_checker import cafr_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last,
	input logic [2:0] out_status
);

	// an error beat closes its burst
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status != ST_OK) |-> out_last && (out_byte == 8'h00))
		else $error("error beat without last or with nonzero byte");

	// every accepted item yields at least one beat
	a_item_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item produced no output beat");

	// empty output side must take items
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("intake stalled with nothing pending");

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last)
			&& $stable(out_status))
		else $error("stalled output beat changed");

endmodule

bind command_apdu_framer_core cafr_checker u_cafr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (cmd.valid),
	.in_ready   (cmd.ready),
	.out_valid  (frame.valid),
	.out_ready  (frame.ready),
	.out_byte   (frame.out_byte),
	.out_last   (frame.last),
	.out_status (frame.status)
);

// ----- sim/apdu_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apdu_frame_checker: frame byte scoreboard for the command APDU framer
// Watches the command channel and the link protocol writes, works out the
// frame bytes each accepted item must produce, and compares every byte beat
// leaving the framer against the oldest byte still owed.
// ----------------------------------------------------------------------------
module apdu_frame_checker import cafr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	cafr_cmd_if        cmd,
	cafr_frame_if      frame,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data,
	output int         mismatches,
	output int         bytes_owed
);

	typedef struct packed {
		logic [7:0] value;
		logic       last;
		status_t    status;
	} frame_byte_t;

	frame_byte_t owed_q[$];

	logic [1:0]  link_proto;
	logic [15:0] bytes_left;
	logic [16:0] open_ne;
	le_mode_t    le_tail;
	logic        frame_open;

	function void owe(input logic [7:0] value, input logic last, input status_t st = ST_OK);
		frame_byte_t b;
		b.value  = value;
		b.last   = last;
		b.status = st;
		owed_q.push_back(b);
	endfunction

	function void close_frame();
		bytes_left = '0;
		open_ne    = '0;
		le_tail    = LE_NONE;
		frame_open = 1'b0;
	endfunction

	function void frame_header(input logic [7:0] cla, input logic [7:0] ins,
			input logic [7:0] p1, input logic [7:0] p2, input logic [15:0] nc,
			input logic [16:0] ne, input logic ext);
		if (ext && link_proto != PROTO_T1)
			owe(8'h00, 1'b1, ST_EXT_NEEDS_T1);
		else if (!ext && nc > 16'd255)
			owe(8'h00, 1'b1, ST_NC_TOO_LARGE);
		else if (ne > (ext ? 17'd65536 : 17'd256))
			owe(8'h00, 1'b1, ST_NE_TOO_LARGE);
		else begin
			owe(cla, 1'b0);
			owe(ins, 1'b0);
			owe(p1, 1'b0);
			if (nc == 16'd0) begin
				// no data: case 1 or a case 2 Le right after the header
				if (ne == 17'd0) begin
					owe(p2, 1'b1);
				end else if (ne <= 17'd256) begin
					owe(p2, 1'b0);
					owe(ne[7:0], 1'b1);
				end else begin
					owe(p2, 1'b0);
					owe(8'h00, 1'b0);
					owe(ne[15:8], 1'b0);
					owe(ne[7:0], 1'b1);
				end
			end else begin
				owe(p2, 1'b0);
				if (nc <= 16'd255 && ne <= 17'd256) begin
					owe(nc[7:0], 1'b0);
					le_tail = (ne == 17'd0) ? LE_NONE : LE_ONE;
				end else begin
					owe(8'h00, 1'b0);
					owe(nc[15:8], 1'b0);
					owe(nc[7:0], 1'b0);
					le_tail = (ne == 17'd0) ? LE_NONE : LE_TWO;
				end
				bytes_left = nc;
				open_ne    = ne;
				frame_open = 1'b1;
			end
		end
	endfunction

	function void frame_data(input logic [7:0] data_byte);
		logic closing;
		closing = (bytes_left == 16'd1);
		owe(data_byte, closing && le_tail == LE_NONE);
		bytes_left = bytes_left - 16'd1;
		if (closing) begin
			// append the Le field held since the header
			if (le_tail == LE_ONE) begin
				owe(open_ne[7:0], 1'b1);
			end else if (le_tail == LE_TWO) begin
				owe(open_ne[15:8], 1'b0);
				owe(open_ne[7:0], 1'b1);
			end
			close_frame();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_byte_t got;
		frame_byte_t want;
		if (!arst_n) begin
			link_proto = 2'd0;
			close_frame();
			owed_q.delete();
			mismatches = 0;
			bytes_owed = 0;
		end else begin
			if (cfg_wr_en)
				link_proto = cfg_wr_data;

			if (cmd.valid && cmd.ready) begin
				if (cmd.op == OP_DATA) begin
					if (frame_open && bytes_left != 16'd0)
						frame_data(cmd.data_byte);
					else
						owe(8'h00, 1'b1, ST_UNEXPECTED);
				end else if (frame_open) begin
					// drop the open frame and the header itself
					close_frame();
					owe(8'h00, 1'b1, ST_UNEXPECTED);
				end else begin
					frame_header(cmd.cla, cmd.ins, cmd.p1, cmd.p2, cmd.data_len,
						cmd.resp_len, cmd.extended);
				end
			end

			if (frame.valid && frame.ready) begin
				got.value  = frame.out_byte;
				got.last   = frame.last;
				got.status = status_t'(frame.status);
				if (owed_q.size() == 0) begin
					$display("%0t: expected nothing, got byte=%h last=%b status=%0d",
						$time, frame.out_byte, frame.last, frame.status);
					mismatches++;
				end else begin
					want = owed_q.pop_front();
					if (got.value !== want.value || got.last !== want.last
							|| got.status !== want.status) begin
						$display("%0t: expected %h/%b/%0d, got %h/%b/%0d",
							$time, want.value, want.last, want.status,
							frame.out_byte, frame.last, frame.status);
						mismatches++;
					end
				end
			end

			bytes_owed = owed_q.size();
		end
	end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: command APDU framer testbench
// Sends directed APDU headers and data bytes covering every case encoding
// and error, then random frames, broken frames and stray items under several
// link protocols and idle patterns; the checker scores every frame byte.
// ----------------------------------------------------------------------------
module tb;
	import cafr_pkg::*;

	localparam int HALF_PERIOD     = 6;
	localparam int RESET_CYCLES    = 7;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int QUIET_LIMIT     = 2000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [1:0] cfg_wr_data;

	cafr_cmd_if   cmd_ch();
	cafr_frame_if frame_ch();

	int         mismatches;
	int         bytes_owed;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         hold_off_reqs = 0;
	int         items_sent = 0;
	int         quiet_cycles = 0;
	logic [1:0] link_proto = 2'd0;

	always #(HALF_PERIOD) clk = ~clk;

	command_apdu_framer_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.frame       (frame_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	apdu_frame_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.frame       (frame_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.mismatches  (mismatches),
		.bytes_owed  (bytes_owed)
	);

	// frame byte receiver: random stalls plus requested long hold-offs
	initial begin
		int holds_granted;
		holds_granted = 0;
		frame_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_granted != hold_off_reqs) begin
				frame_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				holds_granted++;
			end
			frame_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready)
				|| (frame_ch.valid && frame_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(input logic op, input logic [7:0] cla, input logic [7:0] ins,
			input logic [7:0] p1, input logic [7:0] p2, input logic [15:0] nc,
			input logic [16:0] ne, input logic ext, input logic [7:0] data_byte);
		bit took;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.op        <= op;
		cmd_ch.cla       <= cla;
		cmd_ch.ins       <= ins;
		cmd_ch.p1        <= p1;
		cmd_ch.p2        <= p2;
		cmd_ch.data_len  <= nc;
		cmd_ch.resp_len  <= ne;
		cmd_ch.extended  <= ext;
		cmd_ch.data_byte <= data_byte;
		// ready is settled by the falling edge; the beat moves on the next rise
		do begin
			@(negedge clk);
			took = cmd_ch.ready;
			@(posedge clk);
		end while (!took);
		items_sent++;
	endtask

	task automatic send_header(input logic [7:0] cla, input logic [7:0] ins,
			input logic [7:0] p1, input logic [7:0] p2, input logic [15:0] nc,
			input logic [16:0] ne, input logic ext);
		send_item(OP_HEADER, cla, ins, p1, p2, nc, ne, ext, 8'($urandom_range(255)));
	endtask

	task automatic send_rand_header(input logic [15:0] nc, input logic [16:0] ne,
			input logic ext);
		send_header(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), nc, ne, ext);
	endtask

	task automatic send_any_header();
		send_rand_header(16'($urandom_range(65535)), 17'($urandom_range(131071)),
			1'($urandom_range(1)));
	endtask

	task automatic send_data(input logic [7:0] data_byte);
		send_item(OP_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)),
			16'($urandom_range(65535)), 17'($urandom_range(131071)),
			1'($urandom_range(1)), data_byte);
	endtask

	task automatic wait_drain();
		cmd_ch.valid <= 1'b0;
		do @(negedge clk); while (bytes_owed != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_link_protocol(input logic [1:0] proto);
		wait_drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= proto;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		link_proto   = proto;
		@(posedge clk);
	endtask

	function automatic logic [16:0] pick_resp_len(input logic ext);
		int r;
		r = $urandom_range(9);
		if (r < 3)
			return 17'd0;
		else if (r < 6)
			return 17'($urandom_range(1, 256));
		else if (r == 6)
			return 17'd256;
		else if (r == 7)
			return ext ? 17'($urandom_range(257, 65536)) : 17'($urandom_range(1, 255));
		else if (r == 8)
			return ext ? 17'd65536 : 17'd1;
		else
			return ext ? 17'($urandom_range(1, 65536)) : 17'($urandom_range(0, 256));
	endfunction

	// mostly complete frames, some cut short by a header, some stray items
	task automatic send_random_sequence();
		int          pick;
		int          nc;
		int          cut;
		logic        ext;
		logic [16:0] ne;
		pick = $urandom_range(99);
		ext  = (link_proto == PROTO_T1) && ($urandom_range(1) == 1);
		ne   = pick_resp_len(ext);
		if (pick < 70) begin
			nc = ($urandom_range(3) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
			send_rand_header(16'(nc), ne, ext);
			repeat (nc) send_data(8'($urandom_range(255)));
		end else if (pick < 85) begin
			nc  = ext ? $urandom_range(2, 65535) : $urandom_range(2, 255);
			cut = $urandom_range(0, (nc > 4) ? 3 : nc - 1);
			send_rand_header(16'(nc), ne, ext);
			repeat (cut) send_data(8'($urandom_range(255)));
			send_any_header();
		end else if ($urandom_range(1) == 1) begin
			send_data(8'($urandom_range(255)));
		end else begin
			send_any_header();
		end
	endtask

	task automatic send_random(input int count);
		int target;
		target = items_sent + count;
		while (items_sent < target)
			send_random_sequence();
	endtask

	initial begin
		arst_n           <= 1'b0;
		cfg_wr_en        <= 1'b0;
		cfg_wr_data      <= 2'd0;
		cmd_ch.valid     <= 1'b0;
		cmd_ch.op        <= OP_HEADER;
		cmd_ch.cla       <= 8'h00;
		cmd_ch.ins       <= 8'h00;
		cmd_ch.p1        <= 8'h00;
		cmd_ch.p2        <= 8'h00;
		cmd_ch.data_len  <= 16'd0;
		cmd_ch.resp_len  <= 17'd0;
		cmd_ch.extended  <= 1'b0;
		cmd_ch.data_byte <= 8'h00;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// T0 after reset: extended refused, short limits
		send_header(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd0, 17'd0, 1'b1);
		send_header(8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 17'd0, 1'b0);
		send_header(8'hFF, 8'hA4, 8'h04, 8'h00, 16'd0, 17'd256, 1'b0);
		send_data(8'hFF);
		send_header(8'h80, 8'hCA, 8'h9F, 8'h7F, 16'd256, 17'd0, 1'b0);
		send_header(8'h80, 8'hCA, 8'h9F, 8'h7F, 16'd0, 17'd257, 1'b0);

		write_link_protocol(PROTO_T1);
		send_header(8'h00, 8'hB0, 8'h00, 8'h00, 16'd0, 17'd65536, 1'b1);
		send_header(8'h00, 8'hB0, 8'h01, 8'h02, 16'd0, 17'd257, 1'b1);
		send_header(8'h00, 8'hB0, 8'h00, 8'h00, 16'd0, 17'd131071, 1'b1);
		send_header(8'h00, 8'hD6, 8'h00, 8'h00, 16'd1, 17'd0, 1'b0);
		send_data(8'h00);
		send_header(8'h00, 8'h88, 8'h00, 8'h00, 16'd2, 17'd1, 1'b0);
		send_data(8'hFF);
		send_data(8'h5A);
		send_header(8'h00, 8'h2A, 8'h9E, 8'h9A, 16'd1, 17'd65536, 1'b1);
		send_data(8'h81);
		// extended flag with values that fit the short form
		send_header(8'h0C, 8'h20, 8'h00, 8'h81, 16'd1, 17'd256, 1'b1);
		send_data(8'h3C);
		// largest Nc opens a frame; a header then abandons it
		send_header(8'h00, 8'hDA, 8'h01, 8'h00, 16'd65535, 17'd0, 1'b1);
		send_data(8'h12);
		send_data(8'h34);
		send_header(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd0, 17'd0, 1'b0);
		send_data(8'h00);
		send_header(8'h00, 8'hDA, 8'h00, 8'h00, 16'd255, 17'd256, 1'b0);
		send_header(8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 17'd0, 1'b0);

		send_random(20);
		// hold off the receiver while items keep coming, so intake backs up
		hold_off_reqs++;
		send_random(10);
		// three-byte Lc with a two-byte Le, run to completion
		send_rand_header(16'd3, 17'd300, 1'b1);
		repeat (3) send_data(8'($urandom_range(255)));

		send_idle_pct = 82;
		write_link_protocol(2'd2);
		send_random(15);

		send_idle_pct  = 0;
		recv_stall_pct = 82;
		write_link_protocol(PROTO_T1);
		send_random(10);
		wait_drain();
		send_random(10);

		send_idle_pct  = 32;
		recv_stall_pct = 32;
		write_link_protocol(2'd0);
		send_random(15);

		send_idle_pct  = 0;
		recv_stall_pct = 82;
		write_link_protocol(2'd3);
		send_random(10);

		send_idle_pct  = 32;
		recv_stall_pct = 32;
		write_link_protocol(PROTO_T1);
		send_random(15);

		wait_drain();
		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- command_apdu_framer_core.f -----
src/cafr_pkg.sv
src/cafr_if.sv
src/cafr_encode.sv
src/command_apdu_framer_core.sv
src/cafr_checker.sv
sim/apdu_frame_checker.sv
sim/tb.sv
